>>> hw/rtl/rcst_pkg.sv
// ----------------------------------------------------------------------------
// rcst_pkg
// Shared types and constants for the read coverage and start tally block.
// ----------------------------------------------------------------------------
package rcst_pkg;

  localparam int KMER_LEN   = 3;
  localparam int CODE_W     = 3;
  localparam int BASES_W    = KMER_LEN * CODE_W;
  localparam int BIN_W      = 2 * KMER_LEN;
  localparam int NBINS      = 1 << BIN_W;
  localparam int QPOS_W     = 10;
  localparam int RED_W      = 16;
  localparam int DIV_CNT_W  = 5;
  localparam int DIV_STEPS  = 17;     // quotient bits of 0x10000 / d

  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic div_start;  // seed the divider
    logic div_step;   // one restoring step
    logic apply;      // update counters / bins (op 0)
    logic emit;       // load output register
  } rcst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_readout;
    logic needs_div;
    logic last;
  } rcst_sts_t;

  // Bin index of a k-mer; valid low when any code is N or above.
  function automatic logic [BIN_W:0] kmer_index(input logic [BASES_W-1:0] b,
                                                input logic comp);
    logic [BIN_W-1:0] acc;
    logic             ok;
    logic [CODE_W-1:0] c;
    acc = '0;
    ok  = 1'b1;
    for (int i = 0; i < KMER_LEN; i++) begin
      c = b[CODE_W*(KMER_LEN-1-i) +: CODE_W];
      if (c > 3'd3) ok = 1'b0;
      acc[2*(KMER_LEN-1-i) +: 2] = comp ? ~c[1:0] : c[1:0];
    end
    return {ok, acc};
  endfunction

endpackage

>>> hw/rtl/rcst_ram.sv
// ----------------------------------------------------------------------------
// rcst_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rcst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/rcst_ctrl.sv
// ----------------------------------------------------------------------------
// rcst_ctrl
// Sequencer: accept, optional divide, read bins, update, emit for readout or last record.
// ----------------------------------------------------------------------------
module rcst_ctrl import rcst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  logic      clr_busy,
  input  rcst_sts_t sts,
  output rcst_cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD, S_APPLY, S_OUT} state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 ovld_r, ovld_nxt;

  logic accept;
  assign accept    = (state_r == S_IDLE) && in_valid && !clr_busy;
  assign in_stall  = (state_r != S_IDLE) || clr_busy;
  assign out_valid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r && out_stall;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: if (accept) begin
        cmd.load  = 1'b1;
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          cmd.div_start = 1'b1;
          cnt_nxt       = 5'd1;
          if (sts.is_readout || !sts.needs_div) state_nxt = S_RD;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 5'd1;
          if (cnt_r == DIV_CNT_W'(DIV_STEPS)) state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_APPLY;     // bin RAM read latency
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (sts.is_readout || sts.last) state_nxt = S_OUT;
        else state_nxt = S_IDLE;
      end
      S_OUT: if (!ovld_r || !out_stall) begin
        cmd.emit  = 1'b1;
        ovld_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

>>> hw/rtl/rcst_dp.sv
// ----------------------------------------------------------------------------
// rcst_dp
// Counters, reciprocal divider, start histograms and output register.
// ----------------------------------------------------------------------------
module rcst_dp import rcst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  rcst_cmd_t          cmd,
  output rcst_sts_t          sts,
  output logic               clr_busy,
  input  logic               in_op,
  input  logic [31:0]        in_position,
  input  logic [7:0]         in_ref_char,
  input  logic               in_is_deletion,
  input  logic               in_reversed,
  input  logic [15:0]        in_redundancy,
  input  logic [QPOS_W-1:0]  in_query_start,
  input  logic [QPOS_W-1:0]  in_query_end,
  input  logic [QPOS_W-1:0]  in_query_position,
  input  logic [QPOS_W-1:0]  in_read_len,
  input  logic [BASES_W-1:0] in_start_bases,
  input  logic               in_last_in_position,
  output logic [31:0]        out_position,
  output logic [7:0]         out_ref_char,
  output logic [15:0]        out_unique_top,
  output logic [15:0]        out_unique_bot,
  output logic [31:0]        out_redundant_top,
  output logic [31:0]        out_redundant_bot,
  output logic [15:0]        out_raw_redundant_top,
  output logic [15:0]        out_raw_redundant_bot,
  output logic [15:0]        out_begin_top,
  output logic [15:0]        out_begin_bot,
  output logic [31:0]        out_bin_top_count,
  output logic [31:0]        out_bin_bot_count
);

  // captured transaction
  logic               op_r, rev_r, last_r, count_r, uniq_r, first_r;
  logic [31:0]        pos_r;
  logic [7:0]         base_r;
  logic [RED_W-1:0]   red_r;
  logic [BASES_W-1:0] bases_r;

  logic matched;
  assign matched = in_reversed ? (in_query_end == in_read_len) : (in_query_start == 10'd1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      rev_r   <= in_reversed;
      last_r  <= in_last_in_position;
      count_r <= !in_is_deletion && matched;
      uniq_r  <= in_redundancy == 16'd1;
      first_r <= in_reversed ? (in_query_position == in_read_len)
                             : (in_query_position == 10'd1);
      pos_r   <= in_position;
      base_r  <= in_ref_char;
      red_r   <= in_redundancy;
      bases_r <= in_start_bases;
    end
  end

  assign sts.is_readout = op_r == OP_READOUT;
  assign sts.needs_div  = count_r && !uniq_r && red_r != '0;
  assign sts.last       = last_r;

  // restoring divider: 0x10000 / red_r, one quotient bit a step
  logic [RED_W:0]   rem_r;
  logic [RED_W:0]   quo_r;
  logic [RED_W+1:0] trial;
  logic [RED_W:0]   dividend_r;
  assign trial = {rem_r, dividend_r[RED_W]} - {2'b0, red_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r      <= '0;
      quo_r      <= '0;
      dividend_r <= 17'h10000;
    end else if (cmd.div_step) begin
      dividend_r <= {dividend_r[RED_W-1:0], 1'b0};
      if (!trial[RED_W+1]) begin
        rem_r <= trial[RED_W:0];
        quo_r <= {quo_r[RED_W-1:0], 1'b1};
      end else begin
        rem_r <= {rem_r[RED_W-1:0], dividend_r[RED_W]};
        quo_r <= {quo_r[RED_W-1:0], 1'b0};
      end
    end
  end

  logic [31:0] recip;
  assign recip = (red_r == '0) ? 32'h10000 : {15'b0, quo_r};

  // per-position counters
  logic [15:0] uniq_r2 [2];
  logic [15:0] raw_r   [2];
  logic [15:0] start_r [2];
  logic [31:0] sum_r   [2];
  logic [32:0] sum_add;
  assign sum_add = {1'b0, sum_r[rev_r]} + {1'b0, recip};

  // histogram RAMs and clearing pass
  logic [BIN_W:0]   key;
  logic [BIN_W-1:0] clr_idx_r;
  logic             clr_r;
  logic [BIN_W-1:0] addr;
  logic [31:0]      top_q, bot_q;
  logic             we_top, we_bot, tally;
  logic [31:0]      wd_top, wd_bot;

  assign key      = kmer_index(bases_r, rev_r && !op_r);
  assign clr_busy = clr_r;
  assign addr     = clr_r ? clr_idx_r : key[BIN_W-1:0];
  assign tally    = cmd.apply && !op_r && count_r && uniq_r && first_r && key[BIN_W];
  assign we_top   = clr_r || (tally && !rev_r);
  assign we_bot   = clr_r || (tally && rev_r);
  assign wd_top   = clr_r ? '0 : ((top_q == '1) ? top_q : top_q + 32'd1);
  assign wd_bot   = clr_r ? '0 : ((bot_q == '1) ? bot_q : bot_q + 32'd1);

  rcst_ram #(.WIDTH(32), .DEPTH(NBINS)) u_top (
    .clk(clk), .we(we_top), .addr(addr), .wdata(wd_top), .rdata(top_q));
  rcst_ram #(.WIDTH(32), .DEPTH(NBINS)) u_bot (
    .clk(clk), .we(we_bot), .addr(addr), .wdata(wd_bot), .rdata(bot_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == BIN_W'(NBINS - 1)) clr_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        uniq_r2[s] <= '0; raw_r[s] <= '0; start_r[s] <= '0; sum_r[s] <= '0;
      end
    end else if (cmd.emit && !op_r) begin
      for (int s = 0; s < 2; s++) begin
        uniq_r2[s] <= '0; raw_r[s] <= '0; start_r[s] <= '0; sum_r[s] <= '0;
      end
    end else if (cmd.apply && !op_r && count_r) begin
      if (uniq_r) begin
        if (uniq_r2[rev_r] != '1) uniq_r2[rev_r] <= uniq_r2[rev_r] + 16'd1;
        if (first_r && start_r[rev_r] != '1) start_r[rev_r] <= start_r[rev_r] + 16'd1;
      end else begin
        if (raw_r[rev_r] != '1) raw_r[rev_r] <= raw_r[rev_r] + 16'd1;
        sum_r[rev_r] <= sum_add[32] ? '1 : sum_add[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (op_r == OP_READOUT) begin
        out_position <= '0; out_ref_char <= '0;
        out_unique_top <= '0; out_unique_bot <= '0;
        out_redundant_top <= '0; out_redundant_bot <= '0;
        out_raw_redundant_top <= '0; out_raw_redundant_bot <= '0;
        out_begin_top <= '0; out_begin_bot <= '0;
        out_bin_top_count <= key[BIN_W] ? top_q : '0;
        out_bin_bot_count <= key[BIN_W] ? bot_q : '0;
      end else begin
        out_position <= pos_r; out_ref_char <= base_r;
        out_unique_top <= uniq_r2[0]; out_unique_bot <= uniq_r2[1];
        out_redundant_top <= sum_r[0]; out_redundant_bot <= sum_r[1];
        out_raw_redundant_top <= raw_r[0]; out_raw_redundant_bot <= raw_r[1];
        out_begin_top <= start_r[0]; out_begin_bot <= start_r[1];
        out_bin_top_count <= '0; out_bin_bot_count <= '0;
      end
    end
  end

endmodule

>>> hw/rtl/read_coverage_and_start_tally.sv
// ----------------------------------------------------------------------------
// read_coverage_and_start_tally
// Per-position read coverage, reciprocal redundancy sum and start histograms.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_* fields
//   out     | output    | out_valid, out_stall, out_* fields
//
// One transaction at a time; a redundant read also runs the serial restoring
// divider, and a row is emitted for a readout or the last record of a position.
// After reset a clearing pass zeroes all 64 bins of each RAM; in_stall is high.
// A row waiting in the output register holds the sequencer at the next row's emit.
// ----------------------------------------------------------------------------
module read_coverage_and_start_tally import rcst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [31:0]        in_position,
  input  logic [7:0]         in_ref_char,
  input  logic               in_is_deletion,
  input  logic               in_reversed,
  input  logic [15:0]        in_redundancy,
  input  logic [QPOS_W-1:0]  in_query_start,
  input  logic [QPOS_W-1:0]  in_query_end,
  input  logic [QPOS_W-1:0]  in_query_position,
  input  logic [QPOS_W-1:0]  in_read_len,
  input  logic [BASES_W-1:0] in_start_bases,
  input  logic               in_last_in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_position,
  output logic [7:0]         out_ref_char,
  output logic [15:0]        out_unique_top,
  output logic [15:0]        out_unique_bot,
  output logic [31:0]        out_redundant_top,
  output logic [31:0]        out_redundant_bot,
  output logic [15:0]        out_raw_redundant_top,
  output logic [15:0]        out_raw_redundant_bot,
  output logic [15:0]        out_begin_top,
  output logic [15:0]        out_begin_bot,
  output logic [31:0]        out_bin_top_count,
  output logic [31:0]        out_bin_bot_count
);

  rcst_cmd_t cmd;
  rcst_sts_t sts;
  logic      clr_busy;

  rcst_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .clr_busy, .sts, .cmd);

  rcst_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .clr_busy,
    .in_op, .in_position, .in_ref_char, .in_is_deletion, .in_reversed,
    .in_redundancy, .in_query_start, .in_query_end, .in_query_position,
    .in_read_len, .in_start_bases, .in_last_in_position,
    .out_position, .out_ref_char, .out_unique_top, .out_unique_bot,
    .out_redundant_top, .out_redundant_bot, .out_raw_redundant_top,
    .out_raw_redundant_bot, .out_begin_top, .out_begin_bot,
    .out_bin_top_count, .out_bin_bot_count);

  // no transaction taken while the bins are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> in_stall) else $error("accept during clear");

  // an emit always leaves a valid row
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid) else $error("emit lost");

  // apply and load never coincide
  a_apply_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.apply && cmd.load)) else $error("apply with load");

endmodule
